// ----- hdl/wavp_pkg.sv -----
package wavp_pkg;

    localparam int BYTE_W   = 8;
    localparam int WORD_W   = 32;
    localparam int SAMPLE_W = 24;
    localparam int CODE_W   = 3;
    localparam int CNT_W    = 3;

    // chunk and form tags, little-endian as gathered
    localparam logic [WORD_W-1:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [WORD_W-1:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [WORD_W-1:0] TAG_FMT  = 32'h2074_6d66;
    localparam logic [WORD_W-1:0] TAG_DATA = 32'h6174_6164;

    localparam logic [WORD_W-1:0] RATE_RESET = 32'd44100;

    localparam logic [15:0] FMT_PCM      = 16'd1;
    localparam logic [15:0] NUM_CHANNELS = 16'd2;
    localparam logic [15:0] BLOCK_ALIGN  = 16'd6;
    localparam logic [15:0] BITS_PER_SMP = 16'd24;

    localparam logic [CNT_W-1:0] LEN_WORD   = 3'd4;
    localparam logic [CNT_W-1:0] LEN_SAMPLE = 3'd3;
    localparam logic [CNT_W-1:0] LEN_HALF   = 3'd2;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_ERROR  = 1'b1;

    localparam logic [CODE_W-1:0] ERR_NO_RIFF   = 3'd0;
    localparam logic [CODE_W-1:0] ERR_NO_WAVE   = 3'd1;
    localparam logic [CODE_W-1:0] ERR_NOT_PCM   = 3'd2;
    localparam logic [CODE_W-1:0] ERR_NOT_STEREO = 3'd3;
    localparam logic [CODE_W-1:0] ERR_RATE      = 3'd4;
    localparam logic [CODE_W-1:0] ERR_ALIGN     = 3'd5;
    localparam logic [CODE_W-1:0] ERR_BITS      = 3'd6;

    typedef enum logic [3:0] {
        PH_RIFF      = 4'd0,
        PH_FILESIZE  = 4'd1,
        PH_WAVE      = 4'd2,
        PH_CHUNK_ID  = 4'd3,
        PH_FMT_SIZE  = 4'd4,
        PH_FORMAT    = 4'd5,
        PH_CHANNELS  = 4'd6,
        PH_RATE      = 4'd7,
        PH_BYTERATE  = 4'd8,
        PH_ALIGN     = 4'd9,
        PH_BITS      = 4'd10,
        PH_FMT_REST  = 4'd11,
        PH_DATA_SIZE = 4'd12,
        PH_SAMPLES   = 4'd13,
        PH_UNK_SIZE  = 4'd14,
        PH_UNK_SKIP  = 4'd15
    } t_phase;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              start_of_file;
    } t_in_beat;

    typedef struct packed {
        logic                       kind;
        logic signed [SAMPLE_W-1:0] sample;
        logic [CODE_W-1:0]          error_code;
    } t_result;

endpackage

// ----- hdl/wavp_in_if.sv -----
interface wavp_in_if
    import wavp_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              start_of_file;

    modport source (output valid, output data_byte, output start_of_file, input ready);
    modport sink (input valid, input data_byte, input start_of_file, output ready);
endinterface

// ----- hdl/wavp_out_if.sv -----
interface wavp_out_if
    import wavp_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic                       kind;
    logic signed [SAMPLE_W-1:0] sample;
    logic [CODE_W-1:0]          error_code;

    modport source (output valid, output kind, output sample, output error_code, input ready);
    modport sink (input valid, input kind, input sample, input error_code, output ready);
endinterface

// ----- hdl/wavp_cfg_if.sv -----
interface wavp_cfg_if
    import wavp_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/wavp_in_stage.sv -----
module wavp_in_stage
    import wavp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_in_beat i_beat,
    input  logic     i_advance,
    output logic     o_ready,
    output logic     o_valid,
    output t_in_beat o_beat
);

    logic     r_valid;
    t_in_beat r_beat;

    // space when empty or when the held beat moves on this cycle
    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_beat  = r_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_beat <= i_beat;
        end
    end

endmodule

// ----- hdl/wavp_parser.sv -----
module wavp_parser
    import wavp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_advance,
    input  t_in_beat          i_beat,
    input  logic [WORD_W-1:0] i_rate,
    output logic              o_res_valid,
    output t_result           o_result
);

    t_phase             r_phase, n_phase;
    logic               r_failed, n_failed;
    logic [WORD_W-1:0]  r_gathered, n_gathered;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_field_len, n_field_len;
    logic [WORD_W-1:0]  r_chunk_len, n_chunk_len;
    logic [WORD_W-1:0]  r_chunk_pos, n_chunk_pos;

    always_comb begin
        logic [WORD_W-1:0] pos_inc;
        logic [15:0]       half;

        n_phase     = r_phase;
        n_failed    = r_failed;
        n_gathered  = r_gathered;
        n_count     = r_count;
        n_field_len = r_field_len;
        n_chunk_len = r_chunk_len;
        n_chunk_pos = r_chunk_pos;
        o_res_valid = 1'b0;
        o_result    = '0;
        pos_inc     = '0;
        half        = '0;

        if (i_beat.start_of_file) begin
            n_phase     = PH_RIFF;
            n_failed    = 1'b0;
            n_gathered  = '0;
            n_count     = '0;
            n_field_len = LEN_WORD;
            n_chunk_len = '0;
            n_chunk_pos = '0;
        end

        if (!n_failed) begin
            if (n_count < LEN_WORD) begin
                n_gathered[{n_count[1:0], 3'b000} +: BYTE_W] = i_beat.data_byte;
                n_count = n_count + 3'd1;
            end

            // chunk ends on the first byte past its length
            pos_inc = n_chunk_pos + 32'd1;
            if (n_chunk_len != '0) begin
                n_chunk_pos = pos_inc;
                if (pos_inc > n_chunk_len) begin
                    n_field_len = LEN_WORD;
                    n_phase     = PH_CHUNK_ID;
                    n_chunk_len = '0;
                end
            end

            if (n_count == n_field_len) begin
                half = n_gathered[15:0];
                case (n_phase)
                    PH_RIFF: begin
                        if (n_gathered != TAG_RIFF) begin
                            n_failed            = 1'b1;
                            o_res_valid         = 1'b1;
                            o_result.kind       = KIND_ERROR;
                            o_result.error_code = ERR_NO_RIFF;
                        end
                        n_phase = PH_FILESIZE;
                    end
                    PH_FILESIZE: begin
                        n_phase = PH_WAVE;
                    end
                    PH_WAVE: begin
                        if (n_gathered != TAG_WAVE) begin
                            n_failed            = 1'b1;
                            o_res_valid         = 1'b1;
                            o_result.kind       = KIND_ERROR;
                            o_result.error_code = ERR_NO_WAVE;
                        end
                        n_phase = PH_CHUNK_ID;
                    end
                    PH_CHUNK_ID: begin
                        if (n_gathered == TAG_FMT) begin
                            n_phase = PH_FMT_SIZE;
                        end else if (n_gathered == TAG_DATA) begin
                            n_phase = PH_DATA_SIZE;
                        end else begin
                            n_phase = PH_UNK_SIZE;
                        end
                    end
                    PH_FMT_SIZE: begin
                        n_chunk_len = n_gathered;
                        n_field_len = LEN_HALF;
                        n_chunk_pos = '0;
                        n_phase     = PH_FORMAT;
                    end
                    PH_DATA_SIZE: begin
                        n_chunk_len = n_gathered;
                        n_field_len = LEN_SAMPLE;
                        n_chunk_pos = '0;
                        n_phase     = PH_SAMPLES;
                    end
                    PH_UNK_SIZE: begin
                        n_chunk_len = n_gathered;
                        n_field_len = LEN_WORD;
                        n_chunk_pos = '0;
                        n_phase     = PH_UNK_SKIP;
                    end
                    PH_FORMAT: begin
                        if (half != FMT_PCM) begin
                            n_failed            = 1'b1;
                            o_res_valid         = 1'b1;
                            o_result.kind       = KIND_ERROR;
                            o_result.error_code = ERR_NOT_PCM;
                        end
                        n_phase = PH_CHANNELS;
                    end
                    PH_CHANNELS: begin
                        if (half != NUM_CHANNELS) begin
                            n_failed            = 1'b1;
                            o_res_valid         = 1'b1;
                            o_result.kind       = KIND_ERROR;
                            o_result.error_code = ERR_NOT_STEREO;
                        end
                        n_field_len = LEN_WORD;
                        n_phase     = PH_RATE;
                    end
                    PH_RATE: begin
                        if (n_gathered != i_rate) begin
                            n_failed            = 1'b1;
                            o_res_valid         = 1'b1;
                            o_result.kind       = KIND_ERROR;
                            o_result.error_code = ERR_RATE;
                        end
                        n_phase = PH_BYTERATE;
                    end
                    PH_BYTERATE: begin
                        n_field_len = LEN_HALF;
                        n_phase     = PH_ALIGN;
                    end
                    PH_ALIGN: begin
                        if (half != BLOCK_ALIGN) begin
                            n_failed            = 1'b1;
                            o_res_valid         = 1'b1;
                            o_result.kind       = KIND_ERROR;
                            o_result.error_code = ERR_ALIGN;
                        end
                        n_phase = PH_BITS;
                    end
                    PH_BITS: begin
                        if (half != BITS_PER_SMP) begin
                            n_failed            = 1'b1;
                            o_res_valid         = 1'b1;
                            o_result.kind       = KIND_ERROR;
                            o_result.error_code = ERR_BITS;
                        end
                        n_phase = PH_FMT_REST;
                    end
                    PH_SAMPLES: begin
                        // top byte keeps the sign, as later partial fields see it
                        n_gathered = {{(WORD_W-SAMPLE_W){n_gathered[SAMPLE_W-1]}},
                                      n_gathered[SAMPLE_W-1:0]};
                        o_res_valid     = 1'b1;
                        o_result.kind   = KIND_SAMPLE;
                        o_result.sample = n_gathered[SAMPLE_W-1:0];
                    end
                    default: begin
                        // skipped fmt pairs and unknown chunk words
                    end
                endcase
                n_count = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_RIFF;
            r_failed    <= 1'b0;
            r_gathered  <= '0;
            r_count     <= '0;
            r_field_len <= LEN_WORD;
            r_chunk_len <= '0;
            r_chunk_pos <= '0;
        end else if (i_advance) begin
            r_phase     <= n_phase;
            r_failed    <= n_failed;
            r_gathered  <= n_gathered;
            r_count     <= n_count;
            r_field_len <= n_field_len;
            r_chunk_len <= n_chunk_len;
            r_chunk_pos <= n_chunk_pos;
        end
    end

endmodule

// ----- hdl/wavp_out_stage.sv -----
module wavp_out_stage
    import wavp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_ready,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

// ----- hdl/wav_header_parser_sample_unpacker_top.sv -----
// wav file parser and 24-bit stereo sample unpacker
//
// i_in carries one byte of the file per beat; start_of_file on a beat
// clears all parse state before that byte is used. o_out carries one
// result per beat: kind 0 is a signed sample, kind 1 a format
// error with its code. after the first error nothing more is sent until
// the next start of file. i_cfg writes the required sample rate and is
// always ready; the user must write it only while the block is idle.
//
// path: a byte accepted into the input register goes through the parser's
// combinational state update, and any result it yields into the result register.
// throughput: one byte per cycle while o_out is not held, set by the state
// update between the two registers.
// reset: parse state returns to expecting the riff tag, the rate register
// to 44100, both registers empty.
// stall: while o_out is held the result register keeps its beat; the input
// register still takes one more byte, then i_in.ready drops.
module wav_header_parser_sample_unpacker_top
    import wavp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    wavp_in_if.sink    i_in,
    wavp_out_if.source o_out,
    wavp_cfg_if.sink   i_cfg
);

    logic [WORD_W-1:0] r_rate;

    t_in_beat in_beat;
    t_in_beat held_beat;
    logic     held_valid;
    logic     out_valid;
    logic     advance;
    logic     res_valid;
    t_result  res;
    t_result  out_res;

    assign in_beat.data_byte     = i_in.data_byte;
    assign in_beat.start_of_file = i_in.start_of_file;

    // held byte moves on when the result register is free or draining
    assign advance = held_valid && (!out_valid || o_out.ready);

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate <= RATE_RESET;
        end else if (i_cfg.valid) begin
            r_rate <= i_cfg.data;
        end
    end

    wavp_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in.valid),
        .i_beat    (in_beat),
        .i_advance (advance),
        .o_ready   (i_in.ready),
        .o_valid   (held_valid),
        .o_beat    (held_beat)
    );

    wavp_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (advance),
        .i_beat      (held_beat),
        .i_rate      (r_rate),
        .o_res_valid (res_valid),
        .o_result    (res)
    );

    wavp_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance && res_valid),
        .i_result (res),
        .i_ready  (o_out.ready),
        .o_valid  (out_valid),
        .o_result (out_res)
    );

    assign o_out.valid      = out_valid;
    assign o_out.kind       = out_res.kind;
    assign o_out.sample     = out_res.sample;
    assign o_out.error_code = out_res.error_code;

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
    import wavp_pkg::*;

    localparam int PHASES        = 6;
    localparam int PHASE_BYTES   = 140;   // bytes of file data offered per phase
    localparam int HOLD_CYCLES   = 400;   // long output hold-off, fills the block
    localparam int SETTLE_CYCLES = 4;     // two-register latency plus margin
    localparam int REPORT_LIMIT  = 10;

    // how the two ends of the block idle in a phase
    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idling;

    // which defect, if any, a generated file carries
    typedef enum int {
        FLAW_NONE,
        FLAW_RIFF,
        FLAW_WAVE,
        FLAW_FORMAT,
        FLAW_CHANNELS,
        FLAW_RATE,
        FLAW_ALIGN,
        FLAW_BITS,
        FLAW_SHORT_FMT,
        FLAW_NOISE
    } t_flaw;

    logic clk = 1'b0;
    logic rst_n;

    wavp_in_if  in_bus ();
    wavp_out_if out_bus ();
    wavp_cfg_if cfg_bus ();

    wav_header_parser_sample_unpacker_top u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus),
        .i_cfg   (cfg_bus)
    );

    always #5 clk = ~clk;

    // file bytes waiting to be offered, and results the parser owes us
    t_in_beat byte_queue [$];
    t_result  awaited_results [$];

    int beats_queued;
    int beats_taken;
    int rate_writes;
    int files_built;
    int send_gap_pct;
    int recv_stall_pct;
    int holds_asked;
    int holds_granted;
    int hold_left;
    int fail_count;
    int samples_checked;
    int errors_checked;
    int input_stalls;
    logic [7:0] codes_seen;
    bit byte_taken;                 // input beat moved at the last rising edge
    logic [WORD_W-1:0] phase_rate;  // rate the files of the current phase declare

    // parser state as the block should hold it
    logic [WORD_W-1:0] want_rate;
    t_phase            pr_phase;
    bit                pr_failed;
    logic [WORD_W-1:0] pr_word;
    logic [CNT_W-1:0]  pr_count;
    logic [CNT_W-1:0]  pr_flen;
    logic [WORD_W-1:0] pr_clen;
    logic [WORD_W-1:0] pr_cpos;

    task automatic restart_parse();
        pr_phase  = PH_RIFF;
        pr_failed = 1'b0;
        pr_word   = '0;
        pr_count  = '0;
        pr_flen   = LEN_WORD;
        pr_clen   = '0;
        pr_cpos   = '0;
    endtask

    // one file byte through the parser; queues the sample or error it causes
    task automatic predict_wav_byte(input t_in_beat beat);
        t_result           res;
        logic [15:0]       half;
        logic [CODE_W-1:0] code;
        bit                bad;
        if (beat.start_of_file)
            restart_parse();
        if (pr_failed)
            return;
        if (pr_count < LEN_WORD) begin
            pr_word[8*pr_count +: 8] = beat.data_byte;
            pr_count++;
        end
        // chunk walk: the byte past the counted length starts the next chunk id
        if (pr_clen != 0) begin
            pr_cpos++;
            if (pr_cpos > pr_clen) begin
                pr_flen  = LEN_WORD;
                pr_phase = PH_CHUNK_ID;
                pr_clen  = '0;
            end
        end
        if (pr_count != pr_flen)
            return;
        half = pr_word[15:0];
        bad  = 1'b0;
        code = ERR_NO_RIFF;
        case (pr_phase)
            PH_RIFF: begin
                bad      = (pr_word != TAG_RIFF);
                code     = ERR_NO_RIFF;
                pr_phase = PH_FILESIZE;
            end
            PH_FILESIZE: pr_phase = PH_WAVE;
            PH_WAVE: begin
                bad      = (pr_word != TAG_WAVE);
                code     = ERR_NO_WAVE;
                pr_phase = PH_CHUNK_ID;
            end
            PH_CHUNK_ID: begin
                if (pr_word == TAG_FMT)
                    pr_phase = PH_FMT_SIZE;
                else if (pr_word == TAG_DATA)
                    pr_phase = PH_DATA_SIZE;
                else
                    pr_phase = PH_UNK_SIZE;
            end
            PH_FMT_SIZE, PH_DATA_SIZE, PH_UNK_SIZE: begin
                pr_clen = pr_word;
                pr_cpos = '0;
                case (pr_phase)
                    PH_FMT_SIZE: begin
                        pr_flen  = LEN_HALF;
                        pr_phase = PH_FORMAT;
                    end
                    PH_DATA_SIZE: begin
                        pr_flen  = LEN_SAMPLE;
                        pr_phase = PH_SAMPLES;
                    end
                    default: begin
                        pr_flen  = LEN_WORD;
                        pr_phase = PH_UNK_SKIP;
                    end
                endcase
            end
            PH_FORMAT: begin
                bad      = (half != FMT_PCM);
                code     = ERR_NOT_PCM;
                pr_phase = PH_CHANNELS;
            end
            PH_CHANNELS: begin
                bad      = (half != NUM_CHANNELS);
                code     = ERR_NOT_STEREO;
                pr_flen  = LEN_WORD;
                pr_phase = PH_RATE;
            end
            PH_RATE: begin
                bad      = (pr_word != want_rate);
                code     = ERR_RATE;
                pr_phase = PH_BYTERATE;
            end
            PH_BYTERATE: begin
                pr_flen  = LEN_HALF;
                pr_phase = PH_ALIGN;
            end
            PH_ALIGN: begin
                bad      = (half != BLOCK_ALIGN);
                code     = ERR_ALIGN;
                pr_phase = PH_BITS;
            end
            PH_BITS: begin
                bad      = (half != BITS_PER_SMP);
                code     = ERR_BITS;
                pr_phase = PH_FMT_REST;
            end
            PH_SAMPLES: begin
                res.kind       = KIND_SAMPLE;
                res.sample     = pr_word[SAMPLE_W-1:0];
                res.error_code = '0;
                awaited_results.push_back(res);
                // the gathered word keeps the sign-extended sample
                pr_word = {{8{pr_word[SAMPLE_W-1]}}, pr_word[SAMPLE_W-1:0]};
            end
            default: ;
        endcase
        if (bad) begin
            pr_failed      = 1'b1;
            res.kind       = KIND_ERROR;
            res.sample     = '0;
            res.error_code = code;
            awaited_results.push_back(res);
        end
        pr_count = '0;
    endtask

    // compare one result beat with the oldest owed result
    task automatic check_result();
        t_result want;
        if (awaited_results.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
                $display("unexpected result beat: kind %0d sample %0d code %0d",
                         out_bus.kind, out_bus.sample, out_bus.error_code);
            return;
        end
        want = awaited_results.pop_front();
        if (out_bus.kind !== want.kind || out_bus.sample !== want.sample ||
            out_bus.error_code !== want.error_code) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
                $display("result mismatch: expected kind %0d sample %0d code %0d, got kind %0d sample %0d code %0d",
                         want.kind, want.sample, want.error_code,
                         out_bus.kind, out_bus.sample, out_bus.error_code);
        end
        if (want.kind == KIND_SAMPLE)
            samples_checked++;
        else begin
            errors_checked++;
            codes_seen[want.error_code] = 1'b1;
        end
    endtask

    // ---------------------------------------------------------------
    // stimulus building: whole files, little-endian, one byte per beat
    // ---------------------------------------------------------------

    task automatic put_le(input logic [31:0] value, input int count, input bit sof = 1'b0);
        t_in_beat beat;
        for (int i = 0; i < count; i++) begin
            beat.data_byte     = value[8*i +: 8];
            beat.start_of_file = sof && (i == 0);
            byte_queue.push_back(beat);
            beats_queued++;
        end
    endtask

    function automatic logic [31:0] flip_bit(input logic [31:0] value, input int width);
        return value ^ (32'd1 << $urandom_range(width - 1, 0));
    endfunction

    // chunk of an unknown kind, skipped in groups of four
    task automatic add_skip_chunk();
        logic [31:0] tag;
        int          len;
        tag = $urandom;
        if (tag == TAG_FMT || tag == TAG_DATA)
            tag = ~tag;
        len = $urandom_range(12, 1);
        put_le(tag, 4);
        put_le(len, 4);
        repeat (len) put_le($urandom, 1);
    endtask

    task automatic add_file(input t_flaw flaw, input bit open_data);
        logic [31:0] word;
        logic [7:0]  smp;
        int          extra;
        int          count;
        files_built++;
        // loose bytes with the odd start of file among them
        if (flaw == FLAW_NOISE) begin
            count = $urandom_range(20, 4);
            repeat (count) put_le($urandom, 1, $urandom_range(7, 0) == 0);
            return;
        end
        word = (flaw == FLAW_RIFF) ? flip_bit(TAG_RIFF, 32) : TAG_RIFF;
        put_le(word, 4, 1'b1);
        put_le($urandom, 4);
        word = (flaw == FLAW_WAVE) ? flip_bit(TAG_WAVE, 32) : TAG_WAVE;
        put_le(word, 4);
        if ($urandom_range(3, 0) == 0)
            add_skip_chunk();

        // fmt chunk, optionally with trailing bytes skipped in pairs
        extra = 2 * $urandom_range(2, 0);
        put_le(TAG_FMT, 4);
        if (flaw == FLAW_SHORT_FMT)
            put_le($urandom_range(15, 1), 4);
        else
            put_le(16 + extra, 4);
        put_le((flaw == FLAW_FORMAT)   ? flip_bit(FMT_PCM, 16)      : FMT_PCM, 2);
        put_le((flaw == FLAW_CHANNELS) ? flip_bit(NUM_CHANNELS, 16) : NUM_CHANNELS, 2);
        put_le((flaw == FLAW_RATE)     ? flip_bit(phase_rate, 32)   : phase_rate, 4);
        put_le($urandom, 4);
        put_le((flaw == FLAW_ALIGN)    ? flip_bit(BLOCK_ALIGN, 16)  : BLOCK_ALIGN, 2);
        put_le((flaw == FLAW_BITS)     ? flip_bit(BITS_PER_SMP, 16) : BITS_PER_SMP, 2);
        repeat (extra) put_le($urandom, 1);
        if ($urandom_range(3, 0) == 0)
            add_skip_chunk();

        // data chunk; a size of zero never ends, a ragged size ends mid-sample
        count = 3 * $urandom_range(12, 1);
        if ($urandom_range(3, 0) == 0)
            count -= $urandom_range(2, 1);
        put_le(TAG_DATA, 4);
        put_le(open_data ? 0 : count, 4);
        repeat (count) begin
            case ($urandom_range(5, 0))
                0:       smp = 8'h00;
                1:       smp = 8'hff;
                2:       smp = 8'h80;
                3:       smp = 8'h7f;
                default: smp = $urandom;
            endcase
            put_le(smp, 1);
        end
        if (!open_data && $urandom_range(2, 0) == 0)
            add_skip_chunk();
    endtask

    // all offered bytes taken and all owed results seen, then let it settle
    task automatic wait_idle();
        do @(negedge clk);
        while (beats_taken != beats_queued || awaited_results.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // ---------------------------------------------------------------
    // byte driver: new beat at the falling edge once the last one went
    // ---------------------------------------------------------------
    always @(negedge clk) begin : feed
        t_in_beat beat;
        if (!rst_n)
            in_bus.valid <= 1'b0;
        else if (!in_bus.valid || byte_taken) begin
            if (byte_queue.size() != 0 && $urandom_range(99, 0) >= send_gap_pct) begin
                beat = byte_queue.pop_front();
                in_bus.valid         <= 1'b1;
                in_bus.data_byte     <= beat.data_byte;
                in_bus.start_of_file <= beat.start_of_file;
            end else
                in_bus.valid <= 1'b0;
        end
    end

    // result receiver: random stalls, plus the long hold-off when asked
    always @(negedge clk) begin
        if (hold_left > 0) begin
            hold_left--;
            out_bus.ready <= 1'b0;
        end else if (holds_granted < holds_asked) begin
            holds_granted++;
            hold_left = HOLD_CYCLES - 1;
            out_bus.ready <= 1'b0;
        end else
            out_bus.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end

    // ---------------------------------------------------------------
    // monitor: everything is sampled at the rising edge
    // ---------------------------------------------------------------
    always @(posedge clk) begin : watch
        t_in_beat beat;
        if (!rst_n)
            byte_taken = 1'b0;
        else begin
            if (out_bus.valid && out_bus.ready)
                check_result();
            if (in_bus.valid && !in_bus.ready)
                input_stalls++;
            byte_taken = in_bus.valid && in_bus.ready;
            if (byte_taken) begin
                beat.data_byte     = in_bus.data_byte;
                beat.start_of_file = in_bus.start_of_file;
                predict_wav_byte(beat);
                beats_taken++;
            end
            if (cfg_bus.valid && cfg_bus.ready) begin
                want_rate = cfg_bus.data;
                rate_writes++;
            end
        end
    end

    // ---------------------------------------------------------------
    // sequencing: directed bytes, then phases of random files, each
    // phase with its own sample rate and idling pattern
    // ---------------------------------------------------------------
    initial begin : main
        logic [WORD_W-1:0] plan_rate [PHASES];
        t_idling           plan_idle [PHASES];
        int                quota;
        int                seen;
        int                r;

        plan_rate[0] = RATE_RESET;      plan_idle[0] = IDLE_NONE;
        plan_rate[1] = '0;              plan_idle[1] = IDLE_SENDER;
        plan_rate[2] = '1;              plan_idle[2] = IDLE_RECEIVER;
        plan_rate[3] = $urandom;        plan_idle[3] = IDLE_BOTH;
        plan_rate[4] = 32'd48000;       plan_idle[4] = IDLE_NONE;
        plan_rate[5] = RATE_RESET;      plan_idle[5] = IDLE_BOTH;

        rst_n                = 1'b0;
        in_bus.valid         = 1'b0;
        in_bus.data_byte     = '0;
        in_bus.start_of_file = 1'b0;
        out_bus.ready        = 1'b0;
        cfg_bus.valid        = 1'b0;
        cfg_bus.data         = '0;
        send_gap_pct         = 0;
        recv_stall_pct       = 0;
        codes_seen           = '0;
        want_rate            = RATE_RESET;
        phase_rate           = RATE_RESET;
        restart_parse();

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        for (int ph = 0; ph < PHASES; ph++) begin
            // rate register only moves once the parser has drained
            if (ph > 0) begin
                wait_idle();
                seen = rate_writes;
                cfg_bus.data  <= plan_rate[ph];
                cfg_bus.valid <= 1'b1;
                do @(negedge clk);
                while (rate_writes == seen);
                cfg_bus.valid <= 1'b0;
            end
            phase_rate = plan_rate[ph];

            case (plan_idle[ph])
                IDLE_SENDER:   begin send_gap_pct = 85; recv_stall_pct = 0;  end
                IDLE_RECEIVER: begin send_gap_pct = 0;  recv_stall_pct = 85; end
                IDLE_BOTH:     begin send_gap_pct = 30; recv_stall_pct = 30; end
                default:       begin send_gap_pct = 0;  recv_stall_pct = 0;  end
            endcase

            if (ph == 0) begin
                // bad riff tag, bytes ignored while failed, then bad wave tag
                put_le(TAG_RIFF ^ 32'h0100_0000, 4, 1'b1);
                put_le(8'h00, 1);
                put_le(8'hff, 1);
                put_le(TAG_RIFF, 4, 1'b1);
                put_le(32'hffff_ffff, 4);
                put_le(TAG_WAVE ^ 32'h0000_0001, 4);
                put_le(8'h80, 1);
                // one file per defect, then a data chunk that never closes
                for (int f = FLAW_RIFF; f <= FLAW_SHORT_FMT; f++)
                    add_file(t_flaw'(f), 1'b0);
                add_file(FLAW_NONE, 1'b1);
            end

            // output held off for a long stretch while bytes keep coming
            if (ph == 4)
                holds_asked++;

            quota = beats_queued + PHASE_BYTES;
            while (beats_queued < quota) begin
                r = $urandom_range(99, 0);
                if (r < 65)
                    add_file(FLAW_NONE, r < 7);
                else
                    add_file(t_flaw'($urandom_range(FLAW_NOISE, FLAW_RIFF)), 1'b0);
            end
        end

        wait_idle();
        repeat (10) @(negedge clk);

        if (awaited_results.size() != 0) begin
            $display("%0d results never arrived", awaited_results.size());
            fail_count += awaited_results.size();
        end

        $display("covered %0d bytes in %0d files over %0d rate settings: %0d samples, %0d format errors",
                 beats_taken, files_built, rate_writes + 1, samples_checked, errors_checked);
        $display("error codes seen %b, input back-pressure on %0d cycles, %0d mismatches",
                 codes_seen, input_stalls, fail_count);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // generous fixed limit, far beyond the slowest correct run
    initial begin : watchdog
        #2_000_000;
        $display("timeout: %0d of %0d bytes taken, %0d results outstanding",
                 beats_taken, beats_queued, awaited_results.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- wav_header_parser_sample_unpacker_top.f -----
hdl/wavp_pkg.sv
hdl/wavp_in_if.sv
hdl/wavp_out_if.sv
hdl/wavp_cfg_if.sv
hdl/wavp_in_stage.sv
hdl/wavp_parser.sv
hdl/wavp_out_stage.sv
hdl/wav_header_parser_sample_unpacker_top.sv
tb/sv/tb_top.sv
